// ----- hdl/heartbeat_watchdog_table_defines.svh -----
// Assertion macros shared by the watchdog table RTL.
// Each check is sampled on clk and disabled while rst is high.
`ifndef HEARTBEAT_WATCHDOG_TABLE_DEFINES_SVH
`define HEARTBEAT_WATCHDOG_TABLE_DEFINES_SVH

// Implication style check: prop is a full property expression.
`define HWT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Condition that must never be true.
`define HWT_NEVER(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);

`endif

// ----- hdl/hwt_pkg.sv -----
// Types and constants for the heartbeat watchdog table.
// No dependencies; used by every module of the block but hwt_cmp.
package hwt_pkg;

  localparam int MAX_OUT = 16;

  localparam logic [15:0] GAP_LIMIT_RST     = 16'd1250;
  localparam logic [15:0] SILENCE_LIMIT_RST = 16'd5000;
  localparam logic [7:0]  LATE_LIMIT_RST    = 8'd5;
  localparam logic [15:0] EXEMPT_ID_RST     = 16'd258;
  localparam logic [7:0]  LATE_MAX          = 8'hff;

  typedef enum logic [2:0] {
    CMD_REGISTER  = 3'd0,
    CMD_HEARTBEAT = 3'd1,
    CMD_TICK      = 3'd2,
    CMD_CHECK     = 3'd3,
    CMD_RESTARTED = 3'd4
  } cmd_e;

  typedef enum logic [1:0] {
    KIND_HEARTBEAT = 2'd0,
    KIND_RESTART   = 2'd1,
    KIND_REG_ACK   = 2'd2,
    KIND_RST_ACK   = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    CODE_OK      = 2'd0,
    CODE_UNKNOWN = 2'd1,
    CODE_FULL    = 2'd2,
    CODE_PRESENT = 2'd3
  } code_e;

  typedef enum logic [2:0] {
    CFG_GAP_LIMIT     = 3'd0,
    CFG_SILENCE_LIMIT = 3'd1,
    CFG_LATE_LIMIT    = 3'd2,
    CFG_EXEMPT_ID     = 3'd3
  } cfg_idx_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_FIND_RD,
    ST_FIND_EV,
    ST_MISS,
    ST_SCAN_RD,
    ST_SCAN_EV,
    ST_FLUSH,
    ST_EMIT
  } state_e;

  typedef struct packed {
    logic [2:0]  cmd;
    logic [15:0] app_id;
    logic [15:0] sequence_req;
    logic [7:0]  flags_byte;
  } item_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [1:0]  code;
    logic [15:0] app_id_out;
    logic [2:0]  app_status;
    logic [4:0]  app_flags;
    logic        seq_gap;
    logic        status_changed;
    logic        last;
  } result_t;

  typedef struct packed {
    logic [15:0] gap_limit_ms;
    logic [15:0] silence_limit_ms;
    logic [7:0]  late_limit;
    logic [15:0] exempt_id;
  } cfg_t;

  typedef struct packed {
    logic [15:0] id;
    logic [2:0]  status;
    logic [4:0]  flags;
    logic [15:0] seq;
    logic [31:0] arrival;
    logic [7:0]  late;
  } entry_t;

endpackage

// ----- hdl/hwt_mem.sv -----
// Entry table storage: one write port, one registered read port.
// Depends on hwt_pkg for the entry layout.
module hwt_mem #(
  parameter int DEPTH = 16,
  parameter int AW    = 4
) (
  input  logic              clk,
  input  logic              we,
  input  logic [AW-1:0]     waddr,
  input  hwt_pkg::entry_t   wdata,
  input  logic [AW-1:0]     raddr,
  output hwt_pkg::entry_t   rdata
);

  hwt_pkg::entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- hdl/hwt_cmp.sv -----
// Shared elapsed-time comparator: (now - stamp) mod 2^32 > limit.
// Used for the late test on heartbeats and the silence test on checks.
module hwt_cmp (
  input  logic [31:0] now_ms,
  input  logic [31:0] stamp,
  input  logic [15:0] limit,
  output logic        over
);

  logic [31:0] elapsed;

  assign elapsed = now_ms - stamp;
  assign over    = elapsed > {16'd0, limit};

endmodule

// ----- hdl/hwt_ctrl.sv -----
// Sequencer of the watchdog table: id search, table scan, result register.
// Depends on hwt_pkg and heartbeat_watchdog_table_defines.svh.
`include "heartbeat_watchdog_table_defines.svh"

module hwt_ctrl #(
  parameter int SLOTS = 16,
  parameter int IW    = 4
) (
  input  logic              clk,
  input  logic              rst,
  input  hwt_pkg::cfg_t     cfg,
  input  logic              in_valid,
  output logic              in_ready,
  input  hwt_pkg::item_t    in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output hwt_pkg::result_t  out_data,
  output logic              mem_we,
  output logic [IW-1:0]     mem_waddr,
  output hwt_pkg::entry_t   mem_wdata,
  output logic [IW-1:0]     mem_raddr,
  input  hwt_pkg::entry_t   rd_data,
  output logic [31:0]       now_ms,
  output logic [15:0]       cmp_limit,
  input  logic              cmp_over
);

  localparam int FW = $clog2(SLOTS + 1);
  localparam int CW = $clog2(hwt_pkg::MAX_OUT + 1);

  hwt_pkg::state_e  state, state_next, ret, ret_next;
  hwt_pkg::item_t   item, item_next;
  hwt_pkg::result_t res, res_next, pend, pend_next, out_data_next;
  logic [IW-1:0]    idx, idx_next;
  logic [FW-1:0]    fill_count, fill_count_next;
  logic [31:0]      now_ms_next;
  logic [SLOTS-1:0] restart_needed, restart_needed_next;
  logic [SLOTS-1:0] valid_mask;
  logic [CW-1:0]    count, count_next;
  logic             pend_valid, pend_valid_next;
  logic             out_valid_next;
  logic             out_load;
  logic             at_end;
  logic             eligible;
  logic             cap_hit;
  logic [2:0]       hb_status;
  logic [4:0]       hb_flags;

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= hwt_pkg::ST_IDLE;
      ret            <= hwt_pkg::ST_IDLE;
      fill_count     <= '0;
      now_ms         <= '0;
      restart_needed <= '0;
      count          <= '0;
      pend_valid     <= 1'b0;
      out_valid      <= 1'b0;
      idx            <= '0;
    end else begin
      state          <= state_next;
      ret            <= ret_next;
      fill_count     <= fill_count_next;
      now_ms         <= now_ms_next;
      restart_needed <= restart_needed_next;
      count          <= count_next;
      pend_valid     <= pend_valid_next;
      out_valid      <= out_valid_next;
      idx            <= idx_next;
    end
  end

  always_ff @(posedge clk) begin
    item     <= item_next;
    res      <= res_next;
    pend     <= pend_next;
    out_data <= out_data_next;
  end

  always_comb begin
    for (int i = 0; i < SLOTS; i++) begin
      valid_mask[i] = FW'(i) < fill_count;
    end
  end

  assign at_end    = (FW'(idx) + FW'(1)) == fill_count;
  assign hb_status = item.flags_byte[2:0];
  assign hb_flags  = item.flags_byte[7:3];
  assign cap_hit   = (count + CW'(1)) == CW'(hwt_pkg::MAX_OUT);
  assign eligible  = (rd_data.seq != 16'd0) && !restart_needed[idx] &&
                     (rd_data.id != cfg.exempt_id) &&
                     (cmp_over || (rd_data.late > cfg.late_limit));
  assign in_ready  = (state == hwt_pkg::ST_IDLE);

  always_comb begin
    state_next          = state;
    ret_next            = ret;
    item_next           = item;
    res_next            = res;
    pend_next           = pend;
    idx_next            = idx;
    fill_count_next     = fill_count;
    now_ms_next         = now_ms;
    restart_needed_next = restart_needed;
    count_next          = count;
    pend_valid_next     = pend_valid;
    out_load            = 1'b0;
    mem_we              = 1'b0;
    mem_waddr           = idx;
    mem_wdata           = rd_data;
    mem_raddr           = idx;
    cmp_limit           = cfg.gap_limit_ms;

    unique case (state)
      hwt_pkg::ST_IDLE: begin
        if (in_valid) begin
          item_next = in_data;
          idx_next  = '0;
          unique case (in_data.cmd)
            hwt_pkg::CMD_TICK: begin
              now_ms_next = now_ms + 32'd1;
            end
            hwt_pkg::CMD_CHECK: begin
              count_next      = '0;
              pend_valid_next = 1'b0;
              if (fill_count != '0) begin
                state_next = hwt_pkg::ST_SCAN_RD;
              end
            end
            hwt_pkg::CMD_REGISTER, hwt_pkg::CMD_HEARTBEAT, hwt_pkg::CMD_RESTARTED: begin
              state_next = (fill_count != '0) ? hwt_pkg::ST_FIND_RD : hwt_pkg::ST_MISS;
            end
            default: ;
          endcase
        end
      end

      hwt_pkg::ST_FIND_RD: begin
        state_next = hwt_pkg::ST_FIND_EV;
      end

      hwt_pkg::ST_FIND_EV: begin
        if (rd_data.id == item.app_id) begin
          res_next                = '0;
          res_next.app_id_out     = item.app_id;
          res_next.last           = 1'b1;
          res_next.code           = hwt_pkg::CODE_OK;
          state_next              = hwt_pkg::ST_EMIT;
          ret_next                = hwt_pkg::ST_IDLE;
          unique case (item.cmd)
            hwt_pkg::CMD_REGISTER: begin
              res_next.kind       = hwt_pkg::KIND_REG_ACK;
              res_next.code       = hwt_pkg::CODE_PRESENT;
              res_next.app_status = rd_data.status;
              res_next.app_flags  = rd_data.flags;
            end
            hwt_pkg::CMD_HEARTBEAT: begin
              // late test uses the old stamp, before it is refreshed
              mem_we            = 1'b1;
              mem_wdata.status  = hb_status;
              mem_wdata.flags   = hb_flags;
              mem_wdata.seq     = item.sequence_req;
              mem_wdata.arrival = now_ms;
              if (cmp_over && rd_data.late != hwt_pkg::LATE_MAX) begin
                mem_wdata.late = rd_data.late + 8'd1;
              end
              res_next.kind           = hwt_pkg::KIND_HEARTBEAT;
              res_next.app_status     = hb_status;
              res_next.app_flags      = hb_flags;
              res_next.seq_gap        = (rd_data.seq != 16'd0) &&
                                        ((rd_data.seq + 16'd1) != item.sequence_req);
              res_next.status_changed = rd_data.status != hb_status;
            end
            default: begin
              mem_we                   = 1'b1;
              mem_wdata.status         = '0;
              mem_wdata.flags          = '0;
              mem_wdata.seq            = '0;
              mem_wdata.late           = '0;
              mem_wdata.arrival        = now_ms;
              restart_needed_next[idx] = 1'b0;
              res_next.kind            = hwt_pkg::KIND_RST_ACK;
            end
          endcase
        end else if (at_end) begin
          state_next = hwt_pkg::ST_MISS;
        end else begin
          idx_next   = idx + IW'(1);
          state_next = hwt_pkg::ST_FIND_RD;
        end
      end

      hwt_pkg::ST_MISS: begin
        res_next            = '0;
        res_next.app_id_out = item.app_id;
        res_next.last       = 1'b1;
        state_next          = hwt_pkg::ST_EMIT;
        ret_next            = hwt_pkg::ST_IDLE;
        unique case (item.cmd)
          hwt_pkg::CMD_REGISTER: begin
            res_next.kind = hwt_pkg::KIND_REG_ACK;
            if (fill_count == FW'(SLOTS)) begin
              res_next.code = hwt_pkg::CODE_FULL;
            end else begin
              res_next.code     = hwt_pkg::CODE_OK;
              mem_we            = 1'b1;
              mem_waddr         = fill_count[IW-1:0];
              mem_wdata         = '0;
              mem_wdata.id      = item.app_id;
              mem_wdata.arrival = now_ms;
              restart_needed_next[fill_count[IW-1:0]] = 1'b0;
              fill_count_next   = fill_count + FW'(1);
            end
          end
          hwt_pkg::CMD_HEARTBEAT: begin
            res_next.kind = hwt_pkg::KIND_HEARTBEAT;
            res_next.code = hwt_pkg::CODE_UNKNOWN;
          end
          default: begin
            res_next.kind = hwt_pkg::KIND_RST_ACK;
            res_next.code = hwt_pkg::CODE_UNKNOWN;
          end
        endcase
      end

      hwt_pkg::ST_SCAN_RD: begin
        state_next = hwt_pkg::ST_SCAN_EV;
      end

      hwt_pkg::ST_SCAN_EV: begin
        cmp_limit = cfg.silence_limit_ms;
        if (eligible) begin
          restart_needed_next[idx] = 1'b1;
          count_next               = count + CW'(1);
          pend_next                = '0;
          pend_next.kind           = hwt_pkg::KIND_RESTART;
          pend_next.code           = hwt_pkg::CODE_OK;
          pend_next.app_id_out     = rd_data.id;
          pend_next.app_status     = rd_data.status;
          pend_next.app_flags      = rd_data.flags;
          pend_valid_next          = 1'b1;
          // one request is held back so the final one can be marked last
          if (pend_valid) begin
            res_next      = pend;
            res_next.last = 1'b0;
            state_next    = hwt_pkg::ST_EMIT;
            ret_next      = (cap_hit || at_end) ? hwt_pkg::ST_FLUSH : hwt_pkg::ST_SCAN_RD;
          end else begin
            state_next = (cap_hit || at_end) ? hwt_pkg::ST_FLUSH : hwt_pkg::ST_SCAN_RD;
          end
        end else begin
          state_next = at_end ? hwt_pkg::ST_FLUSH : hwt_pkg::ST_SCAN_RD;
        end
        if (!at_end) begin
          idx_next = idx + IW'(1);
        end
      end

      hwt_pkg::ST_FLUSH: begin
        if (pend_valid) begin
          res_next        = pend;
          res_next.last   = 1'b1;
          pend_valid_next = 1'b0;
          state_next      = hwt_pkg::ST_EMIT;
          ret_next        = hwt_pkg::ST_IDLE;
        end else begin
          state_next = hwt_pkg::ST_IDLE;
        end
      end

      hwt_pkg::ST_EMIT: begin
        if (!out_valid || out_ready) begin
          out_load   = 1'b1;
          state_next = ret;
        end
      end

      default: begin
        state_next = hwt_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_next = out_valid && !out_ready;
    out_data_next  = out_data;
    if (out_load) begin
      out_valid_next = 1'b1;
      out_data_next  = res;
    end
  end

  `HWT_NEVER(a_fill_bound, fill_count > FW'(SLOTS), "fill count beyond table size")
  `HWT_NEVER(a_flag_unfilled, (restart_needed & ~valid_mask) != '0,
             "restart flag set on an unfilled slot")
  `HWT_NEVER(a_out_overwrite, out_load && out_valid && !out_ready,
             "result register overwritten before transaction")
  `HWT_NEVER(a_check_cap, count > CW'(hwt_pkg::MAX_OUT), "too many restart requests")
  `HWT_ASSERT(a_tick, (in_valid && in_ready && in_data.cmd == hwt_pkg::CMD_TICK) |=>
              (now_ms == $past(now_ms) + 32'd1), "tick did not advance clock")

endmodule

// ----- hdl/heartbeat_watchdog_table.sv -----
// Heartbeat watchdog table: tick is done on acceptance; register, heartbeat, restarted
// read and evaluate each slot searched (FIND_RD, FIND_EV), then MISS on a miss, then EMIT
// to load the result. Check reads and evaluates filled slots (SCAN_RD, SCAN_EV), with an
// EMIT per restart request and a final FLUSH. Searches and scans use one registered table
// read port. Sync reset empties the table and zeroes the clock; no clearing pass.
module heartbeat_watchdog_table #(
  parameter int SLOTS = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  hwt_pkg::item_t    in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output hwt_pkg::result_t  out_data,
  input  logic              cfg_we,
  input  logic [2:0]        cfg_index,
  input  logic [15:0]       cfg_data
);

  localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  hwt_pkg::cfg_t   cfg;
  hwt_pkg::entry_t mem_wdata, rd_data;
  logic [IW-1:0]   mem_waddr, mem_raddr;
  logic            mem_we;
  logic [31:0]     now_ms;
  logic [15:0]     cmp_limit;
  logic            cmp_over;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.gap_limit_ms     <= hwt_pkg::GAP_LIMIT_RST;
      cfg.silence_limit_ms <= hwt_pkg::SILENCE_LIMIT_RST;
      cfg.late_limit       <= hwt_pkg::LATE_LIMIT_RST;
      cfg.exempt_id        <= hwt_pkg::EXEMPT_ID_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        hwt_pkg::CFG_GAP_LIMIT:     cfg.gap_limit_ms     <= cfg_data;
        hwt_pkg::CFG_SILENCE_LIMIT: cfg.silence_limit_ms <= cfg_data;
        hwt_pkg::CFG_LATE_LIMIT:    cfg.late_limit       <= cfg_data[7:0];
        hwt_pkg::CFG_EXEMPT_ID:     cfg.exempt_id        <= cfg_data;
        default: ;
      endcase
    end
  end

  hwt_mem #(
    .DEPTH (SLOTS),
    .AW    (IW)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (rd_data)
  );

  hwt_cmp u_cmp (
    .now_ms (now_ms),
    .stamp  (rd_data.arrival),
    .limit  (cmp_limit),
    .over   (cmp_over)
  );

  hwt_ctrl #(
    .SLOTS (SLOTS),
    .IW    (IW)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_raddr (mem_raddr),
    .rd_data   (rd_data),
    .now_ms    (now_ms),
    .cmp_limit (cmp_limit),
    .cmp_over  (cmp_over)
  );

endmodule
